// ----- src/microsecond_timer_with_event_deadline_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the microsecond timer core
// Concurrent checks that simulation evaluates; they are empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MICROSECOND_TIMER_WITH_EVENT_DEADLINE_CORE_MACROS_SVH
`define MICROSECOND_TIMER_WITH_EVENT_DEADLINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and ignored during rst.
`define MTED_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk and ignored during rst.
`define MTED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTED_ASSERT(label, ante, cons, msg)
`define MTED_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- src/mted_pkg.sv -----
// ----------------------------------------------------------------------------
// mted_pkg
// Types, widths and codes shared by the microsecond timer controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package mted_pkg;

  localparam int LOW_WORD_BITS = 32;
  localparam int RATE_BITS     = 7;
  localparam int DEADLINE_BITS = 32;
  localparam int TIME_BITS     = 32;
  // The wrap length is rate << (LOW_WORD_BITS - 1), so this holds every raw count.
  localparam int RAW_BITS      = RATE_BITS + LOW_WORD_BITS - 1;
  localparam int PROD_BITS     = DEADLINE_BITS + RATE_BITS;
  // Dividend is twice (raw plus remaining), which needs two bits above RAW_BITS.
  localparam int DIV_BITS      = RAW_BITS + 2;
  localparam int DIV_CNT_BITS  = $clog2(DIV_BITS);

  localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(62);

  localparam logic [2:0] KIND_TICK      = 3'd0;
  localparam logic [2:0] KIND_READ_TIME = 3'd1;
  localparam logic [2:0] KIND_SET_DL    = 3'd2;
  localparam logic [2:0] KIND_CLEAR     = 3'd3;
  localparam logic [2:0] KIND_READ_DL   = 3'd4;

  typedef struct packed {
    logic [2:0]               kind;
    logic [DEADLINE_BITS-1:0] deadline_us;
  } req_word_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] time_us;
    logic                 event_fired;
    logic                 wrapped;
  } rsp_word_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_ARM  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;      // capture the request word
    logic exec;      // carry out the request's first step
    logic arm;       // compare and load the countdown for a deadline set
    logic div_step;  // one restoring division step
    logic push;      // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       div_last;
    logic       out_free;
  } status_t;

endpackage

// ----- src/microsecond_timer_with_event_deadline_core.sv -----
// ----------------------------------------------------------------------------
// microsecond_timer_with_event_deadline_core
// Free-running microsecond timer with one compare event, driven by words.
// ----------------------------------------------------------------------------
// The block counts source-clock ticks in a raw counter that wraps after
// rate * 2^31 ticks, where the rate is set in half-MHz units through
// cfg_wen/cfg_wdata (reset value 62, that is 31 MHz; zero acts as one).
// Each request word carries a kind: a tick advances the counter and the
// countdown and reports whether the counter wrapped or the event fired; a
// time read returns the raw count in microseconds; a deadline set arms the
// countdown for an absolute deadline in microseconds (or for one tick if the
// deadline has passed); a clear disarms it; a deadline read returns the armed
// deadline in microseconds, or the current time while disarmed. Every request
// word produces exactly one response word. Words are handled one at a time:
// after acceptance a tick, a clear or an unknown kind passes through the
// execute and done states, a deadline set through execute, arm and done,
// and either read through execute, the divide steps and done, because the
// microsecond conversion runs through a restoring divider that yields one
// quotient bit per cycle over its 40-bit dividend. The sequencer returns to
// idle as the response enters the output register, and the next request
// word can be accepted from there. A finished word waits in the sequencer
// while the output register still holds a stalled response, which adds the
// length of that stall. The next request word is taken even while the
// previous response is still held by a stall. The rate register should only
// be written while no request is in progress.
// ----------------------------------------------------------------------------
module microsecond_timer_with_event_deadline_core
  import mted_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [RATE_BITS-1:0] cfg_wdata,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_word_t            req_word,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_word_t            rsp_word
);

  // Commands from the sequencer and status back from the datapath.
  cmd_t    cmd;
  status_t status;

  // The sequencer owns the request handshake and the order of the steps.
  mted_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds all timer state, the divider and the response register.
  mted_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req_word  (req_word),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

endmodule

// ----- src/mted_ctrl.sv -----
// ----------------------------------------------------------------------------
// mted_ctrl
// Sequencer for the timer: one request word at a time, from capture to result.
// ----------------------------------------------------------------------------
`include "microsecond_timer_with_event_deadline_core_macros.svh"

module mted_ctrl
  import mted_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.kind == KIND_SET_DL) begin
          state_next = S_ARM;
        end else if (status.kind == KIND_READ_TIME || status.kind == KIND_READ_DL) begin
          state_next = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_ARM: begin
        cmd.arm    = 1'b1;
        state_next = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `MTED_ASSERT_NEXT(a_accept_starts_exec, req_valid && !req_stall, state == S_EXEC,
                    "accepted word did not start execution")
  `MTED_ASSERT_NEXT(a_push_returns_idle, cmd.push, state == S_IDLE,
                    "controller did not return to idle after a result")
  `MTED_ASSERT(a_div_only_for_reads, state == S_DIV,
               status.kind == KIND_READ_TIME || status.kind == KIND_READ_DL,
               "divider stepped for a kind that reads nothing")

endmodule

// ----- src/mted_datapath.sv -----
// ----------------------------------------------------------------------------
// mted_datapath
// Tick counter, countdown, deadline multiplier, serial divider and output
// register of the timer.
// ----------------------------------------------------------------------------
`include "microsecond_timer_with_event_deadline_core_macros.svh"

module mted_datapath
  import mted_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [RATE_BITS-1:0] cfg_wdata,
  input  req_word_t            req_word,
  input  cmd_t                 cmd,
  output status_t              status,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_word_t            rsp_word
);

  logic [RATE_BITS-1:0]    rate;
  logic [RATE_BITS-1:0]    rate_eff;
  logic [2:0]              kind;
  logic [DEADLINE_BITS-1:0] deadline;
  logic [RAW_BITS-1:0]     raw;
  logic [RAW_BITS-1:0]     remaining;
  logic                    armed;
  logic [PROD_BITS-1:0]    prod;
  logic [DIV_BITS-1:0]     div_q;
  logic [RATE_BITS-1:0]    div_r;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic                    res_fired;
  logic                    res_wrap;

  logic [RAW_BITS-1:0]     span;
  logic [RAW_BITS-1:0]     raw_inc;
  logic                    wrap_now;
  logic                    fire_now;
  logic [RAW_BITS:0]       dl_sum;
  logic [RAW_BITS-1:0]     target;
  logic [RATE_BITS:0]      partial;
  logic                    div_ge;
  logic [RATE_BITS:0]      partial_sub;

  // A rate of zero behaves as the slowest rate, one half-MHz unit.
  assign rate_eff = (rate == '0) ? RATE_BITS'(1) : rate;
  assign span     = {rate_eff, {(LOW_WORD_BITS-1){1'b0}}};
  assign raw_inc  = raw + RAW_BITS'(1);
  assign wrap_now = (raw_inc >= span) || (raw_inc == '0);
  assign fire_now = armed && (remaining <= RAW_BITS'(1));
  assign dl_sum   = {1'b0, raw} + {1'b0, (armed ? remaining : '0)};
  assign target   = RAW_BITS'(prod >> 1);

  assign partial     = {div_r, div_q[DIV_BITS-1]};
  assign div_ge      = (partial >= {1'b0, rate_eff});
  assign partial_sub = partial - {1'b0, rate_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
    end else if (cfg_wen) begin
      rate <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind     <= req_word.kind;
      deadline <= req_word.deadline_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw       <= '0;
      remaining <= '0;
      armed     <= 1'b0;
    end else if (cmd.exec && kind == KIND_TICK) begin
      raw <= wrap_now ? '0 : raw_inc;
      if (armed) begin
        if (fire_now) begin
          remaining <= '0;
          armed     <= 1'b0;
        end else begin
          remaining <= remaining - RAW_BITS'(1);
        end
      end
    end else if (cmd.exec && kind == KIND_CLEAR) begin
      remaining <= '0;
      armed     <= 1'b0;
    end else if (cmd.arm) begin
      // A deadline that is not in the future still fires on the next tick.
      remaining <= (target > raw) ? (target - raw) : RAW_BITS'(1);
      armed     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      prod      <= PROD_BITS'(deadline) * PROD_BITS'(rate_eff);
      res_fired <= (kind == KIND_TICK) && fire_now;
      res_wrap  <= (kind == KIND_TICK) && wrap_now;
      div_r     <= '0;
      div_cnt   <= '0;
      priority if (kind == KIND_READ_TIME) begin
        div_q <= DIV_BITS'({raw, 1'b0});
      end else if (kind == KIND_READ_DL) begin
        div_q <= DIV_BITS'({dl_sum, 1'b0});
      end else begin
        div_q <= '0;
      end
    end else if (cmd.div_step) begin
      div_r   <= div_ge ? partial_sub[RATE_BITS-1:0] : partial[RATE_BITS-1:0];
      div_q   <= {div_q[DIV_BITS-2:0], div_ge};
      div_cnt <= div_cnt + DIV_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp_word.time_us     <= div_q[TIME_BITS-1:0];
      rsp_word.event_fired <= res_fired;
      rsp_word.wrapped     <= res_wrap;
    end
  end

  assign status.kind     = kind;
  assign status.div_last = (div_cnt == DIV_CNT_BITS'(DIV_BITS - 1));
  assign status.out_free = !rsp_valid || !rsp_stall;

  `MTED_ASSERT(a_armed_has_count, armed, remaining != '0,
               "countdown armed with nothing left to count")
  `MTED_ASSERT_NEXT(a_wrap_clears_raw, cmd.exec && kind == KIND_TICK && wrap_now,
                    raw == '0, "wrapping tick did not clear the raw counter")

endmodule
